[rtl/rgbhsl_pkg.sv]
// ----------------------------------------------------------------------------
// rgbhsl_pkg
// Shared widths, pipeline payload types and the divider step function for
// the RGB to HSL converter.
// ----------------------------------------------------------------------------
package rgbhsl_pkg;

	localparam int unsigned CHAN_W        = 8;
	localparam int unsigned HUE_FRAC_BITS = 4;
	localparam int unsigned SAT_FRAC_BITS = 16;
	localparam int unsigned HUE_W         = 13;
	localparam int unsigned SAT_W         = 16;
	localparam int unsigned SUM_W         = CHAN_W + 1;
	localparam int unsigned TOTAL_W       = 17;
	localparam int unsigned QUO_W         = SAT_FRAC_BITS;
	localparam int unsigned NUM_W         = CHAN_W + QUO_W;
	localparam int unsigned STEPS_PER_STAGE = 4;
	localparam int unsigned DIV_STAGES    = QUO_W / STEPS_PER_STAGE;
	localparam int unsigned SECTOR_DEG    = 60;
	localparam int unsigned CHAN_MAX      = (1 << CHAN_W) - 1;
	localparam int unsigned HUE_FULL      = 360 << HUE_FRAC_BITS;

	typedef logic [CHAN_W-1:0] chan_t;

	typedef struct packed {
		chan_t            rem;
		logic [QUO_W-1:0] shreg;
	} div_lane_t;

	typedef struct packed {
		div_lane_t        hue;
		div_lane_t        sat;
		chan_t            d;
		chan_t            den;
		logic [SUM_W-1:0] sum;
		logic             grey;
		logic             sat_full;
	} work_t;

	function automatic div_lane_t div_step(div_lane_t lane, chan_t dv);
		logic [CHAN_W:0] t;
		div_lane_t       res;
		t = {lane.rem, lane.shreg[QUO_W-1]};
		if (t >= {1'b0, dv}) begin
			res.rem   = CHAN_W'(t - {1'b0, dv});
			res.shreg = {lane.shreg[QUO_W-2:0], 1'b1};
		end else begin
			res.rem   = t[CHAN_W-1:0];
			res.shreg = {lane.shreg[QUO_W-2:0], 1'b0};
		end
		return res;
	endfunction

endpackage

[rtl/rgbhsl_pix_if.sv]
// ----------------------------------------------------------------------------
// rgbhsl_pix_if
// Pixel channel: one RGB pixel per transfer.
// ----------------------------------------------------------------------------
interface rgbhsl_pix_if
	import rgbhsl_pkg::*;
	;
	logic  valid;
	logic  ready;
	chan_t red_in;
	chan_t green_in;
	chan_t blue_in;

	modport source (output valid, output red_in, output green_in, output blue_in,
		input ready);
	modport sink (input valid, input red_in, input green_in, input blue_in,
		output ready);
endinterface

[rtl/rgbhsl_hsl_if.sv]
// ----------------------------------------------------------------------------
// rgbhsl_hsl_if
// Result channel: one HSL triple per transfer.
// ----------------------------------------------------------------------------
interface rgbhsl_hsl_if
	import rgbhsl_pkg::*;
	;
	logic             valid;
	logic             ready;
	logic [HUE_W-1:0] hue_out;
	logic [SAT_W-1:0] saturation_out;
	logic [SUM_W-1:0] lightness_sum;

	modport source (output valid, output hue_out, output saturation_out,
		output lightness_sum, input ready);
	modport sink (input valid, input hue_out, input saturation_out,
		input lightness_sum, output ready);
endinterface

[rtl/rgbhsl_prep.sv]
// ----------------------------------------------------------------------------
// rgbhsl_prep
// First pipeline stage: channel extremes, lightness sum, saturation
// denominator and the hue sector numerator, set up for the dividers.
// ----------------------------------------------------------------------------
module rgbhsl_prep
	import rgbhsl_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	rgbhsl_pix_if.sink   pixel,
	output logic         valid_o,
	input  logic         ready_i,
	output work_t        data_o
);

	chan_t              r, g, b, mx, mn, d, den;
	logic [SUM_W-1:0]   sum;
	logic [TOTAL_W-1:0] total;
	logic [NUM_W-1:0]   hue_num;
	work_t              next;
	logic               valid_s1;
	work_t              data_s1;
	logic               take;

	always_comb begin
		r  = pixel.red_in;
		g  = pixel.green_in;
		b  = pixel.blue_in;
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		d   = mx - mn;
		sum = SUM_W'(mx) + SUM_W'(mn);
		den = (sum <= SUM_W'(CHAN_MAX)) ? sum[CHAN_W-1:0]
			: CHAN_W'(SUM_W'(2 * CHAN_MAX) - sum);

		if (r == mx) begin
			if (g >= b) begin
				total = TOTAL_W'(SECTOR_DEG) * TOTAL_W'(g - b);
			end else begin
				total = TOTAL_W'(6 * SECTOR_DEG) * TOTAL_W'(d)
					- TOTAL_W'(SECTOR_DEG) * TOTAL_W'(b - g);
			end
		end else if (g == mx) begin
			total = TOTAL_W'(2 * SECTOR_DEG) * TOTAL_W'(d)
				+ TOTAL_W'(SECTOR_DEG) * TOTAL_W'(b)
				- TOTAL_W'(SECTOR_DEG) * TOTAL_W'(r);
		end else begin
			total = TOTAL_W'(4 * SECTOR_DEG) * TOTAL_W'(d)
				+ TOTAL_W'(SECTOR_DEG) * TOTAL_W'(r)
				- TOTAL_W'(SECTOR_DEG) * TOTAL_W'(g);
		end
		hue_num = NUM_W'(total) << HUE_FRAC_BITS;

		next.hue.rem   = hue_num[NUM_W-1:QUO_W];
		next.hue.shreg = hue_num[QUO_W-1:0];
		next.sat.rem   = d;
		next.sat.shreg = '0;
		next.d         = d;
		next.den       = den;
		next.sum       = sum;
		next.grey      = (d == '0);
		next.sat_full  = (d == den);
	end

	assign take        = !valid_s1 || ready_i;
	assign pixel.ready = take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= pixel.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && pixel.valid) begin
			data_s1 <= next;
		end
	end

	assign valid_o = valid_s1;
	assign data_o  = data_s1;

	a_den_covers_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (data_s1.grey || data_s1.den >= data_s1.d))
		else $error("saturation denominator below channel range");

endmodule

[rtl/rgbhsl_div_stage.sv]
// ----------------------------------------------------------------------------
// rgbhsl_div_stage
// One divider pipeline stage: four restoring division steps for both the
// hue and the saturation quotient, with its own valid and stall handling.
// ----------------------------------------------------------------------------
module rgbhsl_div_stage
	import rgbhsl_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  valid_i,
	output logic  ready_o,
	input  work_t data_i,
	output logic  valid_o,
	input  logic  ready_i,
	output work_t data_o
);

	work_t next;
	logic  valid_q;
	work_t data_q;

	always_comb begin
		next = data_i;
		for (int i = 0; i < STEPS_PER_STAGE; i++) begin
			next.hue = div_step(next.hue, data_i.d);
			next.sat = div_step(next.sat, data_i.den);
		end
	end

	assign ready_o = !valid_q || ready_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready_o) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_o && valid_i) begin
			data_q <= next;
		end
	end

	assign valid_o = valid_q;
	assign data_o  = data_q;

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !ready_i |=> valid_q && $stable(data_q))
		else $error("divider stage lost or changed a stalled item");

endmodule

[rtl/rgbhsl_to_hsl_converter_top_placeholder.sv]
// ----------------------------------------------------------------------------
// rgbhsl_out_stage
// Output selection: applies the grey and full-saturation overrides to the
// quotients of the last divider stage and drives the result channel.
// ----------------------------------------------------------------------------
module rgbhsl_out_stage
	import rgbhsl_pkg::*;
(
	input  logic         valid_i,
	output logic         ready_o,
	input  work_t        data_i,
	rgbhsl_hsl_if.source hsl
);

	assign hsl.valid          = valid_i;
	assign ready_o            = hsl.ready;
	assign hsl.hue_out        = data_i.grey ? '0 : data_i.hue.shreg[HUE_W-1:0];
	assign hsl.saturation_out = data_i.grey ? '0
		: (data_i.sat_full ? {SAT_W{1'b1}} : data_i.sat.shreg[SAT_W-1:0]);
	assign hsl.lightness_sum  = data_i.sum;

endmodule

[rtl/rgb_to_hsl_converter_top.sv]
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter_top
// RGB to HSL converter, one pixel per clock unless the result side stalls, through a five-stage pipeline.
// ----------------------------------------------------------------------------
// The converter accepts one pixel per clock unless the result side stalls and
// returns the results in order from the last divider stage register. The first
// stage finds the channel extremes and sets up both quotients; four divider
// stages then produce four quotient bits each for hue and saturation, so the
// sixteen-bit restoring divisions set the latency. Every stage holds its item
// while the result side stalls and fills empty slots behind it, so the pixel
// side keeps transferring until the whole pipeline is full.
module rgb_to_hsl_converter_top
	import rgbhsl_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	rgbhsl_pix_if.sink   pixel,
	rgbhsl_hsl_if.source hsl
);

	logic  valid_s [DIV_STAGES+1];
	logic  ready_s [DIV_STAGES+1];
	work_t data_s  [DIV_STAGES+1];

	rgbhsl_prep u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixel   (pixel),
		.valid_o (valid_s[0]),
		.ready_i (ready_s[0]),
		.data_o  (data_s[0])
	);

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		rgbhsl_div_stage u_div (
			.clk     (clk),
			.arst_n  (arst_n),
			.valid_i (valid_s[k]),
			.ready_o (ready_s[k]),
			.data_i  (data_s[k]),
			.valid_o (valid_s[k+1]),
			.ready_i (ready_s[k+1]),
			.data_o  (data_s[k+1])
		);
	end

	rgbhsl_out_stage u_out (
		.valid_i (valid_s[DIV_STAGES]),
		.ready_o (ready_s[DIV_STAGES]),
		.data_i  (data_s[DIV_STAGES]),
		.hsl     (hsl)
	);

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsl.valid |-> hsl.hue_out < HUE_W'(HUE_FULL))
		else $error("hue out of range");

	a_light_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsl.valid |-> hsl.lightness_sum <= SUM_W'(2 * CHAN_MAX))
		else $error("lightness sum out of range");

	a_grey_hue: assert property (@(posedge clk) disable iff (!arst_n)
		hsl.valid && hsl.saturation_out == '0 |-> hsl.hue_out == '0)
		else $error("grey pixel with nonzero hue");

endmodule

[dv/tb_rgb_to_hsl_converter_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_to_hsl_converter_top
// Self-checking testbench for the RGB to HSL converter. A directed set of
// pixels covers black, white, greys, primaries, ties for the maximum channel,
// the wrap of negative red-sector hues and full saturation. A weighted random
// stream follows. Each pixel is predicted at its input transfer and checked
// in order against the result channel. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsl_converter_top;
	import rgbhsl_pkg::*;

	localparam int unsigned RANDOM_PIXELS = 1525;
	localparam int unsigned MAX_WAIT      = 10;
	localparam int unsigned DRAIN_CYCLES  = 20;
	localparam int unsigned IDLE_LIMIT    = 1000;

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
	} pixel_t;

	typedef struct packed {
		pixel_t           pix;
		logic [HUE_W-1:0] hue;
		logic [SAT_W-1:0] sat;
		logic [SUM_W-1:0] light;
	} hsl_pixel_t;

	logic clk;
	logic arst_n;

	rgbhsl_pix_if pix_if ();
	rgbhsl_hsl_if hsl_if ();

	rgb_to_hsl_converter_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pix_if),
		.hsl    (hsl_if)
	);

	pixel_t      pixel_q[$];
	hsl_pixel_t  hsl_expected_q[$];
	int unsigned err_count;
	int unsigned gap_cnt;
	int unsigned stall_cnt;
	int unsigned idle_cycles;
	bit          send_calm;
	bit          recv_calm;

	always #5 clk = ~clk;

	function automatic hsl_pixel_t convert_pixel(pixel_t p);
		chan_t       mx;
		chan_t       mn;
		int unsigned d;
		int unsigned sum;
		int unsigned den;
		int unsigned total;
		int unsigned quo;
		hsl_pixel_t  res;
		mx = p.red;
		mn = p.red;
		if (p.green > mx) mx = p.green;
		if (p.blue > mx) mx = p.blue;
		if (p.green < mn) mn = p.green;
		if (p.blue < mn) mn = p.blue;
		d = int'(mx) - int'(mn);
		sum = int'(mx) + int'(mn);
		res.pix = p;
		res.light = SUM_W'(sum);
		res.hue = '0;
		res.sat = '0;
		if (d != 0) begin
			if (p.red == mx) begin
				if (p.green >= p.blue)
					total = SECTOR_DEG * (int'(p.green) - int'(p.blue));
				else
					total = 6 * SECTOR_DEG * d - SECTOR_DEG * (int'(p.blue) - int'(p.green));
			end else if (p.green == mx) begin
				total = 2 * SECTOR_DEG * d + SECTOR_DEG * p.blue - SECTOR_DEG * p.red;
			end else begin
				total = 4 * SECTOR_DEG * d + SECTOR_DEG * p.red - SECTOR_DEG * p.green;
			end
			res.hue = HUE_W'((total << HUE_FRAC_BITS) / d);
			den = (sum <= CHAN_MAX) ? sum : 2 * CHAN_MAX - sum;
			if (den != 0) begin
				quo = (d << SAT_FRAC_BITS) / den;
				res.sat = (quo > (1 << SAT_FRAC_BITS) - 1) ? '1 : SAT_W'(quo);
			end
		end
		return res;
	endfunction

	function automatic chan_t edge_chan();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd254;
			3: return 8'd255;
			4: return 8'd128;
			default: return chan_t'($urandom);
		endcase
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t p;
		chan_t  a;
		chan_t  b;
		p = pixel_t'($urandom);
		case ($urandom_range(0, 9))
			5: begin
				a = chan_t'($urandom);
				p = '{a, a, a};
			end
			6: begin
				a = chan_t'($urandom);
				b = chan_t'($urandom_range(0, a));
				case ($urandom_range(0, 2))
					0: p = '{a, a, b};
					1: p = '{b, a, a};
					default: p = '{a, b, a};
				endcase
			end
			7: p = '{edge_chan(), edge_chan(), edge_chan()};
			8: begin
				a = $urandom_range(0, 1) ? 8'd255 : 8'd0;
				case ($urandom_range(0, 2))
					0: p.red = a;
					1: p.green = a;
					default: p.blue = a;
				endcase
			end
			9: begin
				a = chan_t'($urandom_range(2, 253));
				p = '{a + chan_t'($urandom_range(0, 2)) - 8'd1,
					a + chan_t'($urandom_range(0, 2)) - 8'd1,
					a + chan_t'($urandom_range(0, 2)) - 8'd1};
			end
			default: ;
		endcase
		return p;
	endfunction

	task automatic report_error(string msg);
		$display("[%0t] ERROR: %s", $time, msg);
		err_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		pixel_t p;
		if (!arst_n) begin
			pix_if.valid    <= 1'b0;
			pix_if.red_in   <= '0;
			pix_if.green_in <= '0;
			pix_if.blue_in  <= '0;
			gap_cnt = 0;
		end else begin
			if (pix_if.valid && pix_if.ready)
				hsl_expected_q.push_back(convert_pixel('{pix_if.red_in, pix_if.green_in,
					pix_if.blue_in}));
			if (!(pix_if.valid && !pix_if.ready)) begin
				if (gap_cnt > 0) begin
					gap_cnt--;
					pix_if.valid <= 1'b0;
				end else if (pixel_q.size() > 0) begin
					p = pixel_q.pop_front();
					pix_if.valid    <= 1'b1;
					pix_if.red_in   <= p.red;
					pix_if.green_in <= p.green;
					pix_if.blue_in  <= p.blue;
					if ($urandom_range(0, 49) == 0) send_calm = !send_calm;
					gap_cnt = send_calm ? 0 : $urandom_range(0, MAX_WAIT);
				end else begin
					pix_if.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		hsl_pixel_t want;
		if (!arst_n) begin
			hsl_if.ready <= 1'b0;
			stall_cnt = 0;
		end else begin
			if (hsl_if.valid && hsl_if.ready) begin
				if (hsl_expected_q.size() == 0) begin
					report_error($sformatf("result with no pixel pending: hue %0d sat %0d sum %0d",
						hsl_if.hue_out, hsl_if.saturation_out, hsl_if.lightness_sum));
				end else begin
					want = hsl_expected_q.pop_front();
					if (hsl_if.hue_out !== want.hue)
						report_error($sformatf("rgb (%0d,%0d,%0d) hue got %0d expected %0d",
							want.pix.red, want.pix.green, want.pix.blue,
							hsl_if.hue_out, want.hue));
					if (hsl_if.saturation_out !== want.sat)
						report_error($sformatf("rgb (%0d,%0d,%0d) saturation got %0d expected %0d",
							want.pix.red, want.pix.green, want.pix.blue,
							hsl_if.saturation_out, want.sat));
					if (hsl_if.lightness_sum !== want.light)
						report_error($sformatf("rgb (%0d,%0d,%0d) lightness got %0d expected %0d",
							want.pix.red, want.pix.green, want.pix.blue,
							hsl_if.lightness_sum, want.light));
				end
				if ($urandom_range(0, 49) == 0) recv_calm = !recv_calm;
				stall_cnt = recv_calm ? 0 : $urandom_range(0, MAX_WAIT);
			end
			if (stall_cnt > 0) begin
				stall_cnt--;
				hsl_if.ready <= 1'b0;
			end else begin
				hsl_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((pix_if.valid && pix_if.ready) || (hsl_if.valid && hsl_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("rgb_to_hsl_converter_top verification failed");
				$finish;
			end
		end
	end

	initial begin
		static pixel_t directed[] = '{
			'{8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255}, '{8'd128, 8'd128, 8'd128},
			'{8'd1, 8'd1, 8'd1}, '{8'd255, 8'd0, 8'd0}, '{8'd0, 8'd255, 8'd0},
			'{8'd0, 8'd0, 8'd255}, '{8'd255, 8'd255, 8'd0}, '{8'd0, 8'd255, 8'd255},
			'{8'd255, 8'd0, 8'd255}, '{8'd200, 8'd200, 8'd10}, '{8'd10, 8'd90, 8'd90},
			'{8'd200, 8'd10, 8'd150}, '{8'd200, 8'd150, 8'd10}, '{8'd10, 8'd200, 8'd150},
			'{8'd150, 8'd10, 8'd200}, '{8'd1, 8'd0, 8'd0}, '{8'd0, 8'd1, 8'd0},
			'{8'd0, 8'd0, 8'd1}, '{8'd255, 8'd254, 8'd254}, '{8'd254, 8'd255, 8'd255},
			'{8'd128, 8'd127, 8'd128}, '{8'd127, 8'd255, 8'd0}, '{8'd170, 8'd85, 8'd255}
		};
		clk             = 1'b0;
		arst_n          = 1'b0;
		pix_if.valid    = 1'b0;
		pix_if.red_in   = '0;
		pix_if.green_in = '0;
		pix_if.blue_in  = '0;
		hsl_if.ready    = 1'b0;
		err_count       = 0;
		idle_cycles     = 0;
		send_calm       = 1'b0;
		recv_calm       = 1'b0;
		foreach (directed[i])
			pixel_q.push_back(directed[i]);
		for (int i = 0; i < RANDOM_PIXELS; i++)
			pixel_q.push_back(random_pixel());
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		while (pixel_q.size() > 0 || pix_if.valid || hsl_expected_q.size() > 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (err_count == 0)
			$display("rgb_to_hsl_converter_top verification clean");
		else
			$display("rgb_to_hsl_converter_top verification failed");
		$finish;
	end

endmodule
